@@ sv/tvg_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tvg_pkg: shared types and constants of the touch virtual gamepad
// Button rectangles, event kinds, configuration indexes and sequencer states.
// ----------------------------------------------------------------------------
package tvg_pkg;

  localparam int NUM_BUTTONS_DEF = 6;
  localparam int FINGER_BITS_DEF = 8;
  localparam int NUM_RECTS       = 6;

  typedef enum logic [1:0] {
    EV_DOWN   = 2'd0,
    EV_MOTION = 2'd1,
    EV_UP     = 2'd2,
    EV_TICK   = 2'd3
  } ev_t;

  typedef enum logic [1:0] {
    CFG_JOY_LEFT  = 2'd0,
    CFG_JOY_TOP   = 2'd1,
    CFG_JOY_SIZE  = 2'd2,
    CFG_DEAD_ZONE = 2'd3
  } cfg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_EVAL,
    ST_SQUARE,
    ST_PICK,
    ST_DIV,
    ST_ROOT,
    ST_LIN,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic [9:0] x;
    logic [9:0] y;
  } rect_t;

  // All rectangles are 64 x 64.
  localparam logic [6:0] RECT_SIDE = 7'd64;

  function automatic rect_t btn_rect(input logic [2:0] i);
    rect_t r;
    case (i)
      3'd0:    r = '{x: 10'd650, y: 10'd450};
      3'd1:    r = '{x: 10'd570, y: 10'd480};
      3'd2:    r = '{x: 10'd720, y: 10'd380};
      3'd3:    r = '{x: 10'd500, y: 10'd520};
      3'd4:    r = '{x: 10'd720, y: 10'd20};
      3'd5:    r = '{x: 10'd20,  y: 10'd20};
      default: r = '{x: 10'd0,   y: 10'd0};
    endcase
    return r;
  endfunction

endpackage

@@ sv/touch_virtual_gamepad.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// touch_virtual_gamepad: touch events to a virtual stick and six buttons
// Sequenced datapath with one shared compare-and-subtract step unit.
// ----------------------------------------------------------------------------
// Each accepted item (finger down, motion, finger up, frame tick) yields one
// result item that describes the gamepad after the event. Down, up and tick
// items, and motion of any finger that does not own the stick, run idle,
// evaluate, output: the result is registered in the output state, and the
// next item can be taken once the block is back in idle. A motion of the
// stick finger adds a squaring state, a pick state per component and the
// direction math on one shared 22-bit compare-and-subtract unit that yields
// one result bit per cycle. Inside the dead zone the first pick goes straight
// to output. Between dead zone and radius each component is a 27-step
// restoring divide. Beyond the radius each component is a 31-step divide of
// a^2 * 2^30 by the squared offset followed by a 16-step integer square
// root. The block takes no item while one is in work or while its result
// waits; the result sits in an output register until taken.
// Configuration writes are taken at any time but are only meaningful while
// idle.
// ----------------------------------------------------------------------------
module touch_virtual_gamepad
  import tvg_pkg::*;
#(
  parameter int NUM_BUTTONS = NUM_BUTTONS_DEF,
  parameter int FINGER_BITS = FINGER_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  // configuration
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [9:0]         cfg_data,
  // input channel
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         func,
  input  logic [7:0]         finger_id,
  input  logic [15:0]        touch_x,
  input  logic [15:0]        touch_y,
  // output channel
  output logic               out_valid,
  input  logic               out_stall,
  output logic               stick_active,
  output logic signed [15:0] dir_x,
  output logic signed [15:0] dir_y,
  output logic [10:0]        stick_x,
  output logic [9:0]         stick_y,
  output logic [5:0]         buttons_held,
  output logic [5:0]         buttons_pressed
);

  localparam int NB = (NUM_BUTTONS > NUM_RECTS) ? NUM_RECTS : NUM_BUTTONS;
  localparam int FB = (FINGER_BITS > 8) ? 8 : FINGER_BITS;

  // configuration registers
  logic [9:0] joy_left, joy_top, joy_size;
  logic [7:0] dead_zone;

  always_ff @(posedge clk) begin
    if (rst) begin
      joy_left  <= 10'd50;
      joy_top   <= 10'd380;
      joy_size  <= 10'd160;
      dead_zone <= 8'd5;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_JOY_LEFT:  joy_left  <= cfg_data;
        CFG_JOY_TOP:   joy_top   <= cfg_data;
        CFG_JOY_SIZE:  joy_size  <= cfg_data;
        CFG_DEAD_ZONE: dead_zone <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // gamepad state
  state_t state, state_next;
  logic              stick_held;
  logic [FB-1:0]     stick_finger;
  logic [9:0]        start_x, start_y, current_x, current_y;
  logic signed [15:0] direction_x, direction_y;
  logic [NB-1:0]     held_mask, previous_mask;
  logic [FB-1:0]     holding_finger [NB];

  // latched item
  ev_t        ev;
  logic [FB-1:0] fid;
  logic [9:0] px, py;

  // offsets of the new point from the anchor, and their squares
  logic signed [10:0] dxs, dys;
  logic [9:0]  ax, ay;
  logic        neg_x, neg_y;
  logic [19:0] a2x, a2y;
  logic [20:0] d2;
  logic [19:0] sq_x, sq_y;
  assign dxs  = $signed({1'b0, px}) - $signed({1'b0, start_x});
  assign dys  = $signed({1'b0, py}) - $signed({1'b0, start_y});
  assign sq_x = {10'd0, ax} * {10'd0, ax};
  assign sq_y = {10'd0, ay} * {10'd0, ay};

  // region of the offset
  logic [19:0] s2;
  logic [15:0] dz2;
  logic        beyond, above;
  assign s2     = {10'd0, joy_size} * {10'd0, joy_size};
  assign dz2    = {8'd0, dead_zone} * {8'd0, dead_zone};
  assign beyond = {d2, 2'b00} > {3'd0, s2};
  assign above  = (d2 > {5'd0, dz2}) && (joy_size != 10'd0);

  // point tests
  logic        in_joy;
  logic [10:0] joy_r, joy_b;
  assign joy_r  = {1'b0, joy_left} + {1'b0, joy_size};
  assign joy_b  = {1'b0, joy_top} + {1'b0, joy_size};
  assign in_joy = (px >= joy_left) && ({1'b0, px} < joy_r) &&
                  (py >= joy_top) && ({1'b0, py} < joy_b);

  logic [NB-1:0] btn_hit;
  logic [NB-1:0] btn_first;
  logic [NB-1:0] up_clear;
  always_comb begin
    rect_t r;
    logic  found;
    found = 1'b0;
    for (int i = 0; i < NB; i++) begin
      r = btn_rect(3'(i));
      btn_hit[i] = !held_mask[i] && (px >= r.x) &&
                   ({1'b0, px} < {1'b0, r.x} + 11'(RECT_SIDE)) &&
                   (py >= r.y) && ({1'b0, py} < {1'b0, r.y} + 11'(RECT_SIDE));
      btn_first[i] = btn_hit[i] && !found;
      found = found | btn_hit[i];
      up_clear[i] = held_mask[i] && (holding_finger[i] == fid);
    end
  end

  logic motion_hit;
  assign motion_hit = (ev == EV_MOTION) && stick_held && (fid == stick_finger);

  // component under work
  logic        comp_y;
  logic [9:0]  a_sel;
  logic [19:0] a2_sel;
  logic        neg_sel;
  logic [26:0] lin_num;
  assign a_sel   = comp_y ? ay : ax;
  assign a2_sel  = comp_y ? a2y : a2x;
  assign neg_sel = comp_y ? neg_y : neg_x;
  assign lin_num = {1'b0, a_sel, 16'd0} + {17'd0, joy_size};

  // Shared step unit. Divide: shift one dividend bit into the remainder and
  // subtract the divisor. Root: shift two bits in and subtract 4*root + 1.
  logic [21:0] rem;
  logic [31:0] num;
  logic [31:0] quo;
  logic [4:0]  cnt;
  logic [21:0] opa, opb, diff, rem_next;
  logic        ok;
  always_comb begin
    case (state)
      ST_ROOT: begin
        opa = {3'd0, rem[16:0], num[31:30]};
        opb = {4'd0, quo[15:0], 2'b01};
      end
      ST_LIN: begin
        opa = {10'd0, rem[10:0], num[31]};
        opb = {11'd0, joy_size, 1'b0};
      end
      default: begin
        opa = {rem[20:0], num[31]};
        opb = {1'b0, d2};
      end
    endcase
    ok       = opa >= opb;
    diff     = opa - opb;
    rem_next = ok ? diff : opa;
  end

  // results of the final step
  logic [30:0] div_q;
  logic [15:0] root_q, lin_q, mag_unit, mag_done, dir_val;
  logic [16:0] root_inc;
  assign div_q    = {quo[29:0], ok};
  assign root_q   = {quo[14:0], ok};
  assign lin_q    = {quo[14:0], ok};
  // round half up: floor((floor(32768*a/sqrt(d2)) + 1) / 2)
  assign root_inc = {1'b0, root_q} + 17'd1;
  assign mag_unit = root_inc[16:1];
  assign mag_done = (state == ST_ROOT) ? mag_unit : lin_q;
  assign dir_val  = neg_sel ? (16'd0 - mag_done) : mag_done;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and input stall
  always_comb begin
    state_next = state;
    in_stall   = 1'b1;
    case (state)
      ST_IDLE: begin
        in_stall = rst || (out_valid && out_stall);
        if (in_valid && !in_stall) state_next = ST_EVAL;
      end
      ST_EVAL:   state_next = motion_hit ? ST_SQUARE : ST_OUT;
      ST_SQUARE: state_next = ST_PICK;
      ST_PICK: begin
        if (beyond) state_next = ST_DIV;
        else if (above) state_next = ST_LIN;
        else state_next = ST_OUT;
      end
      ST_DIV: begin
        if (cnt == 5'd30) state_next = ST_ROOT;
      end
      ST_ROOT: begin
        if (cnt == 5'd15) state_next = comp_y ? ST_OUT : ST_PICK;
      end
      ST_LIN: begin
        if (cnt == 5'd26) state_next = comp_y ? ST_OUT : ST_PICK;
      end
      ST_OUT:  state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      stick_held    <= 1'b0;
      stick_finger  <= '0;
      start_x       <= '0;
      start_y       <= '0;
      current_x     <= '0;
      current_y     <= '0;
      direction_x   <= '0;
      direction_y   <= '0;
      held_mask     <= '0;
      previous_mask <= '0;
      out_valid     <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (in_valid && !in_stall) begin
            ev  <= ev_t'(func);
            fid <= finger_id[FB-1:0];
            px  <= 10'(({10'd0, touch_x} * 26'd800) >> 16);
            py  <= 10'(({10'd0, touch_y} * 26'd600) >> 16);
          end
        end
        ST_EVAL: begin
          case (ev)
            EV_DOWN: begin
              if (!stick_held && in_joy) begin
                stick_held   <= 1'b1;
                stick_finger <= fid;
                start_x      <= px;
                current_x    <= px;
                start_y      <= py;
                current_y    <= py;
              end else begin
                held_mask <= held_mask | btn_first;
                for (int i = 0; i < NB; i++) begin
                  if (btn_first[i]) holding_finger[i] <= fid;
                end
              end
            end
            EV_MOTION: begin
              if (motion_hit) begin
                current_x <= px;
                current_y <= py;
              end
            end
            EV_UP: begin
              if (stick_held && fid == stick_finger) begin
                stick_held   <= 1'b0;
                stick_finger <= '0;
                direction_x  <= '0;
                direction_y  <= '0;
              end
              held_mask <= held_mask & ~up_clear;
            end
            EV_TICK: previous_mask <= held_mask;
            default: ;
          endcase
          // offsets of the new point, used only by a stick motion
          ax     <= 10'(dxs[10] ? -dxs : dxs);
          ay     <= 10'(dys[10] ? -dys : dys);
          neg_x  <= dxs[10];
          neg_y  <= dys[10];
          comp_y <= 1'b0;
        end
        ST_SQUARE: begin
          a2x <= sq_x;
          a2y <= sq_y;
          d2  <= {1'b0, sq_x} + {1'b0, sq_y};
        end
        ST_PICK: begin
          // a^2 <= d2, so a^2 / 2 is already below the divisor
          if (beyond) begin
            rem <= {3'd0, a2_sel[19:1]};
            num <= {a2_sel[0], 31'd0};
          end else if (above) begin
            rem <= '0;
            num <= {lin_num, 5'd0};
          end else begin
            direction_x <= '0;
            direction_y <= '0;
          end
          quo <= '0;
          cnt <= '0;
        end
        ST_DIV: begin
          if (cnt == 5'd30) begin
            // hand the quotient to the root
            num <= {1'b0, div_q};
            rem <= '0;
            quo <= '0;
            cnt <= '0;
          end else begin
            num <= {num[30:0], 1'b0};
            rem <= rem_next;
            quo <= {quo[30:0], ok};
            cnt <= cnt + 5'd1;
          end
        end
        ST_ROOT, ST_LIN: begin
          if ((state == ST_ROOT && cnt == 5'd15) || (state == ST_LIN && cnt == 5'd26)) begin
            if (comp_y) direction_y <= $signed(dir_val);
            else direction_x <= $signed(dir_val);
            comp_y <= 1'b1;
          end else begin
            num <= (state == ST_ROOT) ? {num[29:0], 2'b00} : {num[30:0], 1'b0};
            rem <= rem_next;
            quo <= {quo[30:0], ok};
            cnt <= cnt + 5'd1;
          end
        end
        default: ;
      endcase

      if (state == ST_OUT) out_valid <= 1'b1;
      else if (out_valid && !out_stall) out_valid <= 1'b0;
    end
  end

  // output register
  logic [10:0] cx;
  logic [9:0]  half;
  assign half = joy_size >> 1;
  assign cx   = {1'b0, joy_left} + {1'b0, half};
  always_ff @(posedge clk) begin
    if (state == ST_OUT) begin
      stick_active    <= stick_held;
      dir_x           <= direction_x;
      dir_y           <= direction_y;
      stick_x         <= stick_held ? {1'b0, current_x} : cx;
      stick_y         <= stick_held ? current_y : 10'(joy_top + half);
      buttons_held    <= 6'(held_mask);
      buttons_pressed <= 6'(held_mask & ~previous_mask);
    end
  end

endmodule
